// File: sv/tlc_pkg.sv
package tlc_pkg;

	localparam int CAPACITY    = 512;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	localparam int HANDLE_W    = 48;
	localparam int DIM_W       = 14;
	localparam int TIME_W      = 48;
	localparam int STAMP_W     = 32;
	localparam int TTL_W       = 32;
	localparam int MAXE_W      = 10;
	localparam int STATUS_W    = 3;
	localparam int SLOT_OUT_W  = 9;
	localparam int COUNT_OUT_W = 10;

	localparam logic [TTL_W-1:0]  TTL_RESET = TTL_W'(3000);
	localparam logic [MAXE_W-1:0] MAXE_RESET = MAXE_W'(440);

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT      = 3'd0,
		ST_INSERTED = 3'd1,
		ST_EVICTED  = 3'd2,
		ST_FAILED   = 3'd3,
		ST_PRUNED   = 3'd4
	} status_t;

	typedef enum logic {
		CFG_TTL = 1'b0,
		CFG_MAX = 1'b1
	} cfg_idx_t;

	// One cached registration as it travels around the ring.
	typedef struct packed {
		logic                valid;
		logic [HANDLE_W-1:0] handle;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic [TIME_W-1:0]   last_used;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

endpackage

// File: sv/tlc_cell.sv
module tlc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  tlc_pkg::entry_t d,
	output tlc_pkg::entry_t q
);
	import tlc_pkg::*;

	logic   valid_q;
	entry_t data_q;

	// Valid bit clears on reset; the rest of the entry is don't-care until written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= d;
		end
	end

	always_comb begin
		q       = data_q;
		q.valid = valid_q;
	end

endmodule

// File: sv/ttl_lru_handle_cache.sv
// Channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------------
// in       | in_valid / in_stall  | kind, image_handle, image_width, image_height,
//          |                      | now_ms, create_ok
// out      | out_valid / out_stall| status, slot, entry_count, removed_count
// cfg      | cfg_valid / cfg_ready| cfg_index (0 ttl_ms, 1 entry limit), cfg_data
//
// Entries live in a ring of CAPACITY cells that rotates one position per cycle in a pass;
// a single compare unit at the head sees the slots in order, slot k while pos_q is k.
// Prune, hit and failed miss take a scan pass and a decision; an insert adds a place pass.
// Reset clears every valid bit at once and the counters, and loads the config defaults.
// One transaction at a time: in_stall stays high until the result has been taken,
// and the result holds on the out channel while out_stall is high.
module ttl_lru_handle_cache (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [tlc_pkg::HANDLE_W-1:0]     image_handle,
	input  logic [tlc_pkg::DIM_W-1:0]        image_width,
	input  logic [tlc_pkg::DIM_W-1:0]        image_height,
	input  logic [tlc_pkg::TIME_W-1:0]       now_ms,
	input  logic                             create_ok,

	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tlc_pkg::STATUS_W-1:0]     status,
	output logic [tlc_pkg::SLOT_OUT_W-1:0]   slot,
	output logic [tlc_pkg::COUNT_OUT_W-1:0]  entry_count,
	output logic [tlc_pkg::COUNT_OUT_W-1:0]  removed_count,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [tlc_pkg::TTL_W-1:0]        cfg_data
);
	import tlc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_PLACE  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [TTL_W-1:0]  ttl_q;
	logic [MAXE_W-1:0] max_q;

	// Captured transaction
	logic                kind_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [TIME_W-1:0]   now_q;
	logic                ok_q;

	// Scan bookkeeping
	logic [SLOT_W-1:0]  pos_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  hit_slot_q;
	logic               free_found_q;
	logic [SLOT_W-1:0]  free_slot_q;
	logic               vic_found_q;
	logic [SLOT_W-1:0]  victim_q;
	logic [TIME_W-1:0]  best_lu_q;
	logic [STAMP_W-1:0] best_age_q;
	logic [CNT_W-1:0]   removed_q;
	logic               evict_q;
	logic [SLOT_W-1:0]  target_q;

	// Cache-wide state
	logic [STAMP_W-1:0] ic_q;
	logic [CNT_W-1:0]   vcnt_q;

	// Result register
	status_t          res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [CNT_W-1:0] res_count_q;
	logic [CNT_W-1:0] res_removed_q;

	// Ring
	entry_t chain_out [CAPACITY];
	entry_t head;
	entry_t tail_d;
	logic   shift_en;

	logic               last_pos;
	logic               key_match;
	logic [TIME_W-1:0]  head_age;
	logic               expired;
	logic [STAMP_W-1:0] stamp_age;
	logic               older;
	logic               evict_d;
	logic               in_accept;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = (state_q == S_DONE);
	assign cfg_ready = 1'b1;

	assign status        = STATUS_W'(res_status_q);
	assign slot          = SLOT_OUT_W'(res_slot_q);
	assign entry_count   = COUNT_OUT_W'(res_count_q);
	assign removed_count = COUNT_OUT_W'(res_removed_q);

	// Rotate the ring during either pass; the head feeds the tail through the
	// compare unit so each entry is updated as it goes by.
	assign shift_en = (state_q == S_SCAN) || (state_q == S_PLACE);
	assign head     = chain_out[0];
	assign last_pos = (pos_q == SLOT_W'(CAPACITY - 1));

	for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
		if (i == CAPACITY - 1) begin : g_tail
			tlc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (tail_d),
				.q        (chain_out[i])
			);
		end else begin : g_body
			tlc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.d        (chain_out[i+1]),
				.q        (chain_out[i])
			);
		end
	end

	// Compare unit at the head of the ring
	assign key_match = head.valid && (head.handle == handle_q) &&
	                   (head.width == width_q) && (head.height == height_q);
	// A last-use time later than now counts as age zero.
	assign head_age  = (now_q >= head.last_used) ? (now_q - head.last_used) : '0;
	assign expired   = head.valid && (ttl_q != '0) &&
	                   (head_age >= {{(TIME_W-TTL_W){1'b0}}, ttl_q});
	// Insert order: the larger distance from the running counter is older.
	assign stamp_age = ic_q - head.stamp;
	assign older     = (head.last_used < best_lu_q) ||
	                   ((head.last_used == best_lu_q) && (stamp_age > best_age_q));

	always_comb begin
		int limit;
		limit   = (int'(max_q) < CAPACITY) ? int'(max_q) : CAPACITY;
		evict_d = (int'(vcnt_q) >= limit) && (vcnt_q != '0);
	end

	always_comb begin
		tail_d = head;
		if (state_q == S_SCAN) begin
			if (!kind_q && expired) begin
				tail_d.valid = 1'b0;
			end
			if (kind_q && key_match) begin
				tail_d.last_used = now_q;
			end
		end else if (state_q == S_PLACE) begin
			if (pos_q == target_q) begin
				tail_d.valid     = 1'b1;
				tail_d.handle    = handle_q;
				tail_d.width     = width_q;
				tail_d.height    = height_q;
				tail_d.last_used = now_q;
				tail_d.stamp     = ic_q;
			end else if (evict_q && (pos_q == victim_q)) begin
				tail_d.valid = 1'b0;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
			max_q <= MAXE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TTL: ttl_q <= cfg_data;
				CFG_MAX: max_q <= cfg_data[MAXE_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q   <= kind;
			handle_q <= image_handle;
			width_q  <= image_width;
			height_q <= image_height;
			now_q    <= now_ms;
			ok_q     <= create_ok;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pos_q         <= '0;
			hit_q         <= 1'b0;
			hit_slot_q    <= '0;
			free_found_q  <= 1'b0;
			free_slot_q   <= '0;
			vic_found_q   <= 1'b0;
			victim_q      <= '0;
			best_lu_q     <= '0;
			best_age_q    <= '0;
			removed_q     <= '0;
			evict_q       <= 1'b0;
			target_q      <= '0;
			ic_q          <= '0;
			vcnt_q        <= '0;
			res_status_q  <= ST_HIT;
			res_slot_q    <= '0;
			res_count_q   <= '0;
			res_removed_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						pos_q        <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						vic_found_q  <= 1'b0;
						removed_q    <= '0;
						evict_q      <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!kind_q && expired) begin
						removed_q <= removed_q + CNT_W'(1);
					end
					if (kind_q) begin
						if (key_match) begin
							hit_q      <= 1'b1;
							hit_slot_q <= pos_q;
						end
						if (!head.valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_slot_q  <= pos_q;
						end
						if (head.valid && (!vic_found_q || older)) begin
							vic_found_q <= 1'b1;
							victim_q    <= pos_q;
							best_lu_q   <= head.last_used;
							best_age_q  <= stamp_age;
						end
					end
					pos_q <= last_pos ? '0 : pos_q + SLOT_W'(1);
					if (last_pos) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!kind_q) begin
						vcnt_q        <= vcnt_q - removed_q;
						res_count_q   <= vcnt_q - removed_q;
						res_removed_q <= removed_q;
						res_slot_q    <= '0;
						res_status_q  <= ST_PRUNED;
						state_q       <= S_DONE;
					end else if (hit_q) begin
						res_status_q  <= ST_HIT;
						res_slot_q    <= hit_slot_q;
						res_count_q   <= vcnt_q;
						res_removed_q <= '0;
						state_q       <= S_DONE;
					end else if (!ok_q) begin
						res_status_q  <= ST_FAILED;
						res_slot_q    <= '0;
						res_count_q   <= vcnt_q;
						res_removed_q <= '0;
						state_q       <= S_DONE;
					end else begin
						// Lowest free slot after eviction: the victim competes with
						// the first free slot found.
						evict_q <= evict_d;
						if (evict_d && !(free_found_q && (free_slot_q < victim_q))) begin
							target_q <= victim_q;
						end else begin
							target_q <= free_slot_q;
						end
						pos_q   <= '0;
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					pos_q <= last_pos ? '0 : pos_q + SLOT_W'(1);
					if (last_pos) begin
						ic_q          <= ic_q + STAMP_W'(1);
						vcnt_q        <= vcnt_q + CNT_W'(1) - CNT_W'(evict_q);
						res_count_q   <= vcnt_q + CNT_W'(1) - CNT_W'(evict_q);
						res_removed_q <= CNT_W'(evict_q);
						res_slot_q    <= target_q;
						res_status_q  <= evict_q ? ST_EVICTED : ST_INSERTED;
						state_q       <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A hit never removes anything.
	a_hit_no_removal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (res_status_q == ST_HIT)) |-> (res_removed_q == '0))
		else $error("hit reported a removal");

	// An accepted transaction starts a ring pass on the next cycle.
	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == S_SCAN) && (pos_q == '0))
		else $error("accepted transaction did not start a scan");

	// The end of a scan pass always leads to the decision step.
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && last_pos) |=> (state_q == S_DECIDE))
		else $error("scan pass did not end in decision");

	// The entry count never exceeds the ring size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(vcnt_q) <= CAPACITY)
		else $error("entry count above capacity");

endmodule
